// ===== rtl/mchb_pkg.sv =====
// Package for the multi-channel heartbeat monitor: field widths, reset values,
// request and register codes, parameter defaults.
// No dependencies.
`default_nettype none

package mchb_pkg;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF = 6;
    localparam int MAX_REPORTED_DEF = 8;
    localparam int TIME_WIDTH_DEF   = 32;

    // Channels that own an enable bit and a timeout register
    localparam int REG_CHANNELS = 6;

    // Port field widths
    localparam int REQ_W    = 1;
    localparam int CHAN_W   = 3;
    localparam int NOW_W    = 32;
    localparam int MASK_W   = 6;
    localparam int CNT_W    = 4;
    localparam int TMO_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_HEARTBEAT = 1'b0,
        REQ_TICK      = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_TO_REMOTE   = 3'd1,
        CFG_TO_YAW      = 3'd2,
        CFG_TO_PITCH    = 3'd3,
        CFG_TO_TRIGGER  = 3'd4,
        CFG_TO_FRIC_A   = 3'd5,
        CFG_TO_FRIC_B   = 3'd6
    } t_cfg_idx;

    localparam logic [MASK_W-1:0] ENABLE_RST = 6'd63;
    localparam logic [TMO_W-1:0]  TMO_SHORT_RST = 16'd500;
    localparam logic [TMO_W-1:0]  TMO_LONG_RST  = 16'd4000;

    localparam logic [TMO_W-1:0] TIMEOUT_RST [REG_CHANNELS] = '{
        TMO_SHORT_RST, TMO_SHORT_RST, TMO_SHORT_RST,
        TMO_LONG_RST,  TMO_LONG_RST,  TMO_LONG_RST
    };

endpackage

`default_nettype wire

// ===== rtl/multi_channel_heartbeat_monitor.sv =====
// Heartbeat timeout monitor for up to six module channels, single module.
// Depends on mchb_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall): a heartbeat item stores i_now_time as
//   the last-seen time of i_channel; a tick item checks every enabled channel
//   in index order against its timeout and marks it lost or recovered.
//   Output channel (o_valid / i_stall): one result per item, giving the lost
//   mask, the lost count (capped at MAX_REPORTED) and the any-error flag as
//   they stand after that item.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; index 0 is the
//   enable mask, indexes 1 to 6 the per-channel timeouts. Write while idle.
// Timing: an item transferred into the input register moves on to the result
//   register and shows at the output from there; one item per cycle sustained
//   while the output is not stalled, set by the single compare-and-count stage
//   between the input register and the result register.
// Reset: last-seen times, lost mask and count clear, registers take their
//   defaults, both pipeline registers empty.
// Stall: a stalled result holds; the input register keeps filling, and
//   o_stall rises once it holds an item that cannot move on.
`default_nettype none

module multi_channel_heartbeat_monitor #(
    parameter int NUM_CHANNELS = mchb_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_REPORTED = mchb_pkg::MAX_REPORTED_DEF,
    parameter int TIME_WIDTH   = mchb_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input items
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mchb_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [mchb_pkg::CHAN_W-1:0]   i_channel,
    input  wire logic [mchb_pkg::NOW_W-1:0]    i_now_time,
    // results
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [mchb_pkg::MASK_W-1:0]        o_lost_mask,
    output logic [mchb_pkg::CNT_W-1:0]         o_lost_count,
    output logic                               o_any_error,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mchb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mchb_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int REG_CH = mchb_pkg::REG_CHANNELS;
    localparam int CHK_CHANNELS = (NUM_CHANNELS < REG_CH) ? NUM_CHANNELS : REG_CH;
    localparam int MASK_W = mchb_pkg::MASK_W;
    localparam int CNT_W  = mchb_pkg::CNT_W;
    localparam int TMO_W  = mchb_pkg::TMO_W;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_REPORTED);

    // configuration
    logic [MASK_W-1:0] r_enable;
    logic [TMO_W-1:0]  r_timeout [REG_CH];

    // input stage
    logic                   r_in_vld;
    mchb_pkg::t_req         r_in_type;
    logic [mchb_pkg::CHAN_W-1:0] r_in_chan;
    logic [TIME_WIDTH-1:0]  r_in_now;

    // monitor state
    logic [TIME_WIDTH-1:0]  r_last_seen [NUM_CHANNELS];
    logic [TIME_WIDTH-1:0]  n_last_seen [NUM_CHANNELS];
    logic [MASK_W-1:0]      r_lost_bits, n_lost_bits;
    logic [CNT_W-1:0]       r_lost_total, n_lost_total;

    // result stage
    logic                   r_out_vld;
    logic [MASK_W-1:0]      r_out_mask;
    logic [CNT_W-1:0]       r_out_count;
    logic                   r_out_err;

    logic                   move;
    logic                   in_take;
    logic [REG_CH-1:0]      late;
    logic [REG_CH-1:0]      check;

    assign move    = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !move;
    assign in_take = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign o_valid      = r_out_vld;
    assign o_lost_mask  = r_out_mask;
    assign o_lost_count = r_out_count;
    assign o_any_error  = r_out_err;

    // per-channel timeout compare, all in parallel
    always_comb begin
        late  = '0;
        check = '0;
        for (int i = 0; i < CHK_CHANNELS; i++) begin
            check[i] = r_enable[i];
            late[i]  = (r_in_now > r_last_seen[i]) &&
                       ((r_in_now - r_last_seen[i]) > TIME_WIDTH'(r_timeout[i]));
        end
    end

    // state update; the count chain runs in channel order because of the cap
    always_comb begin
        n_lost_bits  = r_lost_bits;
        n_lost_total = r_lost_total;
        n_last_seen  = r_last_seen;
        if (move) begin
            unique case (r_in_type)
                mchb_pkg::REQ_HEARTBEAT: begin
                    for (int j = 0; j < NUM_CHANNELS; j++) begin
                        if (int'(r_in_chan) == j) begin
                            n_last_seen[j] = r_in_now;
                        end
                    end
                end
                mchb_pkg::REQ_TICK: begin
                    for (int i = 0; i < REG_CH; i++) begin
                        if (check[i]) begin
                            if (late[i]) begin
                                if (n_lost_total < CNT_CAP && !n_lost_bits[i]) begin
                                    n_lost_bits[i] = 1'b1;
                                    n_lost_total   = n_lost_total + 1'b1;
                                end
                            end else if (n_lost_bits[i]) begin
                                n_lost_bits[i] = 1'b0;
                                if (n_lost_total != '0) begin
                                    n_lost_total = n_lost_total - 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_lost_bits  <= '0;
            r_lost_total <= '0;
            r_enable     <= mchb_pkg::ENABLE_RST;
            for (int i = 0; i < REG_CH; i++) begin
                r_timeout[i] <= mchb_pkg::TIMEOUT_RST[i];
            end
            for (int j = 0; j < NUM_CHANNELS; j++) begin
                r_last_seen[j] <= '0;
            end
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            r_lost_bits  <= n_lost_bits;
            r_lost_total <= n_lost_total;
            r_last_seen  <= n_last_seen;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    mchb_pkg::CFG_ENABLE:     r_enable     <= i_cfg_data[MASK_W-1:0];
                    mchb_pkg::CFG_TO_REMOTE:  r_timeout[0] <= i_cfg_data;
                    mchb_pkg::CFG_TO_YAW:     r_timeout[1] <= i_cfg_data;
                    mchb_pkg::CFG_TO_PITCH:   r_timeout[2] <= i_cfg_data;
                    mchb_pkg::CFG_TO_TRIGGER: r_timeout[3] <= i_cfg_data;
                    mchb_pkg::CFG_TO_FRIC_A:  r_timeout[4] <= i_cfg_data;
                    mchb_pkg::CFG_TO_FRIC_B:  r_timeout[5] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_type <= mchb_pkg::t_req'(i_req_type);
            r_in_chan <= i_channel;
            r_in_now  <= TIME_WIDTH'(i_now_time);
        end
        if (move) begin
            r_out_mask  <= n_lost_bits;
            r_out_count <= n_lost_total;
            r_out_err   <= (n_lost_total != '0);
        end
    end

`ifndef SYNTH
    // every set lost bit is counted exactly once
    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'($countones(r_lost_bits)) == r_lost_total)
        else $error("lost count does not match lost mask");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lost_total <= CNT_CAP)
        else $error("lost count above cap");

    // a heartbeat never changes the lost state
    a_heartbeat_keeps_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_type == mchb_pkg::REQ_HEARTBEAT) |=> $stable(r_lost_bits))
        else $error("heartbeat changed lost mask");

    // a stalled result is not overwritten by the input stage
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> !move)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
